/* rtl/bsp_pkg.sv */
`timescale 1ns / 1ps
package bsp_pkg;
    localparam int MAX_POINTS      = 64;
    localparam int MAX_ORDER       = 8;
    localparam int COORD_WIDTH     = 16;
    localparam int PARAM_FRAC_BITS = 16;

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int ORD_W   = $clog2(MAX_ORDER);
    localparam int T_W     = PARAM_FRAC_BITS + 1;
    // basis values are at most 1.0, knot gaps at most MAX_ORDER-1 spans
    localparam int W_W     = PARAM_FRAC_BITS + 1;
    localparam int GAP_W   = PARAM_FRAC_BITS + ORD_W;
    localparam int U_W     = PARAM_FRAC_BITS + ADDR_W + 1;
    localparam int NUM_W   = W_W + GAP_W + 1;
    localparam int REM_W   = GAP_W + 1;
    localparam int ACC_W   = W_W + COORD_WIDTH + ORD_W + 1;

    localparam logic [0:0] REG_ORDER = 1'b0;
    localparam logic [0:0] REG_COUNT = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_KNOT,
        ST_MUL,
        ST_DIV,
        ST_WB,
        ST_ACC_RD,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_FINISH
    } state_t;
endpackage

/* rtl/bsp_ram.sv */
`timescale 1ns / 1ps
module bsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/clamped_bspline_evaluator.sv */
`timescale 1ns / 1ps
// Clamped uniform B-spline curve evaluator, 2-D, fixed point.
// Requests come in on req_valid/req_ready. A write request (command 0) stores
// point_x/point_y at point_index in the point RAM and gives no result. An
// evaluate request (command 1) returns one result on rsp_valid/rsp_ready:
// curve_x, curve_y in signed Q4.12 and error_flag.
// Configuration (cfg_we, cfg_index, cfg_data) sets the order and the point
// count; write it only while the block is idle.
// An evaluate runs k(k-1)/2 basis steps after a setup state, each with a knot,
// multiply, restoring divide and write-back state, then a read, multiply and
// add state for each of the k weighted points; the divider takes most of the
// time. A write request is stored as it is taken and the block stays ready. An
// evaluate with an invalid configuration goes straight to the finish state.
// One request is worked on at a time; a new request is taken while a result
// still waits in the output register. If the receiver stalls, the result holds
// and the next evaluate waits before it is returned.
// Reset returns the order and count to 4; point RAM contents are undefined
// until written.
module clamped_bspline_evaluator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [0:0]                             cfg_index,
    input  logic [6:0]                             cfg_data,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic                                   command,
    input  logic [bsp_pkg::ADDR_W-1:0]             point_index,
    input  logic signed [bsp_pkg::COORD_WIDTH-1:0] point_x,
    input  logic signed [bsp_pkg::COORD_WIDTH-1:0] point_y,
    input  logic [bsp_pkg::T_W-1:0]                param_t,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic signed [bsp_pkg::COORD_WIDTH-1:0] curve_x,
    output logic signed [bsp_pkg::COORD_WIDTH-1:0] curve_y,
    output logic                                   error_flag
);
    import bsp_pkg::*;

    localparam logic [W_W-1:0] ONE = W_W'(1) << PARAM_FRAC_BITS;

    state_t state_reg, state_next;

    logic [3:0] order_reg;
    logic [6:0] count_reg;

    logic [PARAM_FRAC_BITS-1:0] t_reg;
    logic [6:0]        m_reg;
    logic [U_W-1:0]    u_reg;
    logic [ADDR_W-1:0] sp_reg;
    logic [ORD_W-1:0]  j_reg, r_reg;
    logic [W_W-1:0]    basis_reg [MAX_ORDER];
    logic [W_W-1:0]    saved_reg, old_reg;
    logic [GAP_W-1:0]  rr_reg, den_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [PARAM_FRAC_BITS:0] lo_reg, quo_reg;
    logic [4:0]        cnt_reg;
    logic signed [W_W+COORD_WIDTH:0] px_reg, py_reg;
    logic signed [ACC_W-1:0] ax_reg, ay_reg;
    logic              err_reg;
    logic              rsp_valid_reg;
    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg;
    logic              eflag_reg;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [2*COORD_WIDTH-1:0]    ram_rdata;

    logic req_acc, cfg_bad, load_out;
    logic last_r, last_j, div_done;

    assign req_acc = req_valid && req_ready;
    assign cfg_bad = (order_reg < 4'd2) || (order_reg > 4'(MAX_ORDER))
                  || (count_reg > 7'(MAX_POINTS)) || (count_reg < {3'd0, order_reg});
    assign last_r   = (r_reg == j_reg - ORD_W'(1));
    assign last_j   = ({1'b0, j_reg} == order_reg - 4'd1);
    assign div_done = (cnt_reg == 5'(PARAM_FRAC_BITS));
    assign load_out = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);
    assign ram_we   = req_acc && (command == CMD_WRITE);

    bsp_ram #(.WIDTH(2*COORD_WIDTH), .DEPTH(MAX_POINTS)) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (point_index),
        .wdata ({point_x, point_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // knot positions for the current step
    logic signed [9:0] ka_idx, kb_idx;
    logic [6:0]        ka_v, kb_v;
    logic [U_W-1:0]    ka, kb;
    logic [GAP_W-1:0]  rr_c, ll_c;
    logic [NUM_W-1:0]  num_c;
    logic [REM_W-1:0]  trial;
    logic              qbit;
    logic [W_W-1:0]    part;
    logic signed [ACC_W-1:0] rx, ry;
    logic signed [ACC_W-PARAM_FRAC_BITS-1:0] qx, qy;

    always_comb
    begin
        ka_idx = 10'(sp_reg) + 10'(r_reg) + 10'sd1;
        kb_idx = 10'(sp_reg) + 10'(r_reg) + 10'sd1 - 10'(j_reg);
        ka_v = (ka_idx > 10'(m_reg)) ? m_reg : ka_idx[6:0];
        if (kb_idx < 0)
        begin
            kb_v = 7'd0;
        end
        else if (kb_idx > 10'(m_reg))
        begin
            kb_v = m_reg;
        end
        else
        begin
            kb_v = kb_idx[6:0];
        end
        ka = U_W'(ka_v) << PARAM_FRAC_BITS;
        kb = U_W'(kb_v) << PARAM_FRAC_BITS;
        rr_c = GAP_W'(ka - u_reg);
        ll_c = GAP_W'(u_reg - kb);
        num_c = NUM_W'(old_reg) * NUM_W'(rr_reg) + NUM_W'(den_reg >> 1);
        trial = {rem_reg[REM_W-2:0], lo_reg[PARAM_FRAC_BITS]};
        qbit  = (trial >= {1'b0, den_reg});
        part  = (den_reg == '0) ? '0 : W_W'(quo_reg);
        rx = ax_reg + (ACC_W'(1) <<< (PARAM_FRAC_BITS - 1));
        ry = ay_reg + (ACC_W'(1) <<< (PARAM_FRAC_BITS - 1));
        qx = rx[ACC_W-1:PARAM_FRAC_BITS];
        qy = ry[ACC_W-1:PARAM_FRAC_BITS];
    end

    function automatic logic signed [COORD_WIDTH-1:0] sat(
        input logic signed [ACC_W-PARAM_FRAC_BITS-1:0] q
    );
        logic signed [ACC_W-PARAM_FRAC_BITS-1:0] hi, lo;
        hi = (ACC_W-PARAM_FRAC_BITS)'((1 << (COORD_WIDTH - 1)) - 1);
        lo = -hi - 1;
        if (q > hi)
        begin
            return hi[COORD_WIDTH-1:0];
        end
        else if (q < lo)
        begin
            return lo[COORD_WIDTH-1:0];
        end
        return q[COORD_WIDTH-1:0];
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && command == CMD_EVAL)
                begin
                    state_next = cfg_bad ? ST_FINISH : ST_SETUP;
                end
            end
            ST_SETUP:   state_next = ST_KNOT;
            ST_KNOT:    state_next = ST_MUL;
            ST_MUL:     state_next = ST_DIV;
            ST_DIV:     state_next = div_done ? ST_WB : ST_DIV;
            ST_WB:      state_next = (last_r && last_j) ? ST_ACC_RD : ST_KNOT;
            ST_ACC_RD:  state_next = ST_ACC_MUL;
            ST_ACC_MUL: state_next = ST_ACC_ADD;
            ST_ACC_ADD:
            begin
                state_next = ({1'b0, r_reg} == order_reg - 4'd1) ? ST_FINISH : ST_ACC_RD;
            end
            ST_FINISH:  state_next = load_out ? ST_IDLE : ST_FINISH;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        ram_raddr = sp_reg + ADDR_W'(r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            order_reg     <= 4'd4;
            count_reg     <= 7'd4;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORDER: order_reg <= cfg_data[3:0];
                    REG_COUNT: count_reg <= cfg_data;
                    default:   order_reg <= order_reg;
                endcase
            end
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                err_reg <= cfg_bad;
                t_reg   <= (param_t >= T_W'(ONE)) ? '1 : param_t[PARAM_FRAC_BITS-1:0];
                m_reg   <= count_reg - {3'd0, order_reg} + 7'd1;
            end
            ST_SETUP:
            begin
                u_reg        <= U_W'(t_reg) * U_W'(m_reg);
                sp_reg       <= ADDR_W'((U_W'(t_reg) * U_W'(m_reg)) >> PARAM_FRAC_BITS);
                basis_reg[0] <= ONE;
                j_reg        <= ORD_W'(1);
                r_reg        <= '0;
                saved_reg    <= '0;
                ax_reg       <= '0;
                ay_reg       <= '0;
            end
            ST_KNOT:
            begin
                rr_reg  <= rr_c;
                den_reg <= rr_c + ll_c;
                old_reg <= basis_reg[r_reg];
            end
            ST_MUL:
            begin
                rem_reg <= num_c[NUM_W-1:PARAM_FRAC_BITS+1];
                lo_reg  <= num_c[PARAM_FRAC_BITS:0];
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= qbit ? trial - {1'b0, den_reg} : trial;
                lo_reg  <= lo_reg << 1;
                quo_reg <= {quo_reg[PARAM_FRAC_BITS-1:0], qbit};
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_WB:
            begin
                basis_reg[r_reg] <= saved_reg + part;
                if (last_r)
                begin
                    basis_reg[j_reg] <= old_reg - part;
                    saved_reg <= '0;
                    r_reg     <= '0;
                    if (!last_j)
                    begin
                        j_reg <= j_reg + ORD_W'(1);
                    end
                end
                else
                begin
                    saved_reg <= old_reg - part;
                    r_reg     <= r_reg + ORD_W'(1);
                end
            end
            ST_ACC_MUL:
            begin
                px_reg <= $signed({1'b0, basis_reg[r_reg]})
                        * $signed(ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH]);
                py_reg <= $signed({1'b0, basis_reg[r_reg]})
                        * $signed(ram_rdata[COORD_WIDTH-1:0]);
            end
            ST_ACC_ADD:
            begin
                ax_reg <= ax_reg + ACC_W'(px_reg);
                ay_reg <= ay_reg + ACC_W'(py_reg);
                r_reg  <= r_reg + ORD_W'(1);
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    cx_reg    <= err_reg ? '0 : sat(qx);
                    cy_reg    <= err_reg ? '0 : sat(qy);
                    eflag_reg <= err_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign rsp_valid  = rsp_valid_reg;
    assign curve_x    = cx_reg;
    assign curve_y    = cy_reg;
    assign error_flag = eflag_reg;
endmodule

/* rtl/bsp_checker.sv */
`timescale 1ns / 1ps
module bsp_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   req_valid,
    input logic                                   req_ready,
    input logic                                   command,
    input logic                                   rsp_valid,
    input logic                                   rsp_ready,
    input logic signed [bsp_pkg::COORD_WIDTH-1:0] curve_x,
    input logic signed [bsp_pkg::COORD_WIDTH-1:0] curve_y,
    input logic                                   error_flag
);
    import bsp_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(curve_x) && $stable(curve_y))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && error_flag |-> curve_x == '0 && curve_y == '0)
        else $error("error result carries nonzero coordinates");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && command == CMD_EVAL |=> !req_ready)
        else $error("ready right after an evaluate request");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && command == CMD_WRITE |=> !$rose(rsp_valid))
        else $error("result after a write request");
endmodule

bind clamped_bspline_evaluator bsp_checker u_bsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .command    (command),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .curve_x    (curve_x),
    .curve_y    (curve_y),
    .error_flag (error_flag)
);

/* test/clamped_bspline_evaluator_checker.sv */
`timescale 1ns / 1ps
module clamped_bspline_evaluator_checker
    import bsp_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [6:0]                    cfg_data,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          command,
    input  logic [ADDR_W-1:0]             point_index,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic [T_W-1:0]                param_t,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic signed [COORD_WIDTH-1:0] curve_x,
    input  logic signed [COORD_WIDTH-1:0] curve_y,
    input  logic                          error_flag,
    output int                            failures,
    output int                            pending,
    output int                            curves_checked,
    output int                            error_answers
);
    localparam longint ONE = longint'(1) << PARAM_FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          err;
    } curve_point_t;

    logic signed [COORD_WIDTH-1:0] ctrl_x [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] ctrl_y [MAX_POINTS];
    logic [3:0] order_reg;
    logic [6:0] count_reg;
    curve_point_t curve_queue [$];

    function automatic longint knot_pos(longint j, longint k, longint m);
        longint v;
        v = j - (k - 1);
        if (v < 0) v = 0;
        if (v > m) v = m;
        return v * ONE;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] round_clip(longint acc);
        longint q;
        // arithmetic shift floors, giving round half up
        q = (acc + (ONE / 2)) >>> PARAM_FRAC_BITS;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[COORD_WIDTH-1:0];
    endfunction

    function automatic curve_point_t evaluate_curve(logic [T_W-1:0] t);
        curve_point_t res;
        longint k, n, m, u, sp, s, tt, sx, sy, w, idx;
        longint unsigned basis [MAX_ORDER+1];
        longint unsigned carry, rr, ll, den, old, part;
        k = order_reg;
        n = count_reg;
        res.x = '0;
        res.y = '0;
        res.err = 1'b1;
        if (k < 2 || k > MAX_ORDER || n > MAX_POINTS || n < k) return res;
        tt = t;
        if (tt >= ONE) tt = ONE - 1;
        m = n - k + 1;
        u = tt * m;
        sp = u >>> PARAM_FRAC_BITS;
        s = sp + k - 1;
        basis[0] = ONE;
        for (int j = 1; j < k; j++)
        begin
            carry = 0;
            for (int r = 0; r < j; r++)
            begin
                rr = knot_pos(s + r + 1, k, m) - u;
                ll = u - knot_pos(s + 1 - j + r, k, m);
                den = rr + ll;
                old = basis[r];
                part = 0;
                if (den != 0) part = (old * rr + den / 2) / den;
                basis[r] = carry + part;
                carry = old - part;
            end
            basis[j] = carry;
        end
        sx = 0;
        sy = 0;
        for (int r = 0; r < k; r++)
        begin
            idx = sp + r;
            w = longint'(basis[r]);
            sx += w * longint'(ctrl_x[idx]);
            sy += w * longint'(ctrl_y[idx]);
        end
        res.x = round_clip(sx);
        res.y = round_clip(sy);
        res.err = 1'b0;
        return res;
    endfunction

    assign pending = curve_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t want;
        if (!rst_n)
        begin
            order_reg <= 4'd4;
            count_reg <= 7'd4;
            curve_queue.delete();
            failures <= 0;
            curves_checked <= 0;
            error_answers <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ORDER) order_reg <= cfg_data[3:0];
                else count_reg <= cfg_data;
            end
            if (req_valid && req_ready)
            begin
                if (command == CMD_WRITE)
                begin
                    ctrl_x[point_index] = point_x;
                    ctrl_y[point_index] = point_y;
                end
                else
                begin
                    curve_queue.push_back(evaluate_curve(param_t));
                end
            end
            if (rsp_valid && rsp_ready)
            begin
                if (curve_queue.size() == 0)
                begin
                    failures <= failures + 1;
                    if (failures < 10)
                        $display("%0t: result with nothing expected: x=%0d y=%0d err=%0b",
                                 $realtime, curve_x, curve_y, error_flag);
                end
                else
                begin
                    want = curve_queue.pop_front();
                    curves_checked <= curves_checked + 1;
                    if (want.err) error_answers <= error_answers + 1;
                    if (want.x !== curve_x || want.y !== curve_y || want.err !== error_flag)
                    begin
                        failures <= failures + 1;
                        if (failures < 10)
                            $display("%0t: mismatch: expected x=%0d y=%0d err=%0b, got x=%0d y=%0d err=%0b",
                                     $realtime, want.x, want.y, want.err,
                                     curve_x, curve_y, error_flag);
                    end
                end
            end
        end
    end
endmodule

/* test/clamped_bspline_evaluator_test.sv */
`timescale 1ns / 1ps
module clamped_bspline_evaluator_test;
    import bsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [0:0]                    cfg_index;
    logic [6:0]                    cfg_data;
    logic                          req_valid;
    logic                          req_ready;
    logic                          command;
    logic [ADDR_W-1:0]             point_index;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic [T_W-1:0]                param_t;
    logic                          rsp_valid;
    logic                          rsp_ready;
    logic signed [COORD_WIDTH-1:0] curve_x;
    logic signed [COORD_WIDTH-1:0] curve_y;
    logic                          error_flag;

    int  failures, pending, curves_checked, error_answers;
    int  writes_sent, evals_sent, phases_run;
    int  quiet_cycles;
    bit  calm;
    bit  hold_ask;

    clamped_bspline_evaluator dut (.*);

    clamped_bspline_evaluator_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_ask = 1'b0;
            end
            rsp_ready <= calm || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(logic cmd, logic [ADDR_W-1:0] idx,
                                logic [15:0] px, logic [15:0] py, logic [T_W-1:0] t);
        while (!calm && $urandom_range(99) < 30)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        command     <= cmd;
        point_index <= idx;
        point_x     <= px;
        point_y     <= py;
        param_t     <= t;
        do @(negedge clk); while (!req_ready);
        @(posedge clk);
        if (cmd == CMD_WRITE) writes_sent++;
        else evals_sent++;
    endtask

    task automatic write_point(int idx, logic [15:0] px, logic [15:0] py);
        send_request(CMD_WRITE, ADDR_W'(idx), px, py, T_W'($urandom_range(131071)));
    endtask

    task automatic evaluate_at(logic [T_W-1:0] t);
        send_request(CMD_EVAL, ADDR_W'($urandom_range(63)), 16'($urandom),
                     16'($urandom), t);
    endtask

    // wait for the block to drain, then change order and count
    task automatic set_shape(logic [3:0] order, logic [6:0] count);
        req_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ORDER;
        cfg_data  <= {3'b000, order};
        @(posedge clk);
        cfg_index <= REG_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        phases_run++;
    endtask

    function automatic logic [T_W-1:0] random_param();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'd65535;
            3: return 17'h10000 | T_W'($urandom_range(65535));
            default: return T_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_phase(int items);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(99) < 35)
                write_point($urandom_range(63), 16'($urandom), 16'($urandom));
            else
                evaluate_at(random_param());
        end
    endtask

    initial
    begin
        int order, count;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ORDER;
        cfg_data = '0;
        req_valid = 1'b0;
        command = CMD_WRITE;
        point_index = '0;
        point_x = '0;
        point_y = '0;
        param_t = '0;
        calm = 1'b0;
        hold_ask = 1'b0;
        writes_sent = 0;
        evals_sent = 0;
        phases_run = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole point memory so no evaluation reads an unwritten entry
        write_point(0, 16'h7FFF, 16'h8000);
        write_point(1, 16'h8000, 16'h7FFF);
        write_point(2, 16'h7FFF, 16'h7FFF);
        write_point(3, 16'h8000, 16'h8000);
        for (int i = 4; i < MAX_POINTS; i++)
            write_point(i, 16'($urandom), 16'($urandom));

        // reset shape: order 4 over 4 points; ends of the parameter range and its midpoint
        evaluate_at(17'd0);
        evaluate_at(17'd65535);
        evaluate_at(17'd65536);
        evaluate_at(17'h1FFFF);
        evaluate_at(17'd32768);

        set_shape(4'd2, 7'd2);
        evaluate_at(17'd0);
        evaluate_at(17'd65536);
        set_shape(4'd8, 7'd64);
        evaluate_at(17'd0);
        evaluate_at(17'd65536);
        evaluate_at(17'd1);
        // too few points, then out-of-range order and count
        set_shape(4'd8, 7'd5);
        evaluate_at(17'd100);
        set_shape(4'd0, 7'd10);
        evaluate_at(17'd100);
        set_shape(4'd1, 7'd10);
        evaluate_at(17'd100);
        set_shape(4'd9, 7'd20);
        evaluate_at(17'd100);
        set_shape(4'd15, 7'd127);
        evaluate_at(17'd100);
        set_shape(4'd4, 7'd65);
        evaluate_at(17'd100);

        // fill the block and its output register behind a long receiver hold
        set_shape(4'd8, 7'd16);
        hold_ask = 1'b1;
        for (int i = 0; i < 6; i++)
            evaluate_at(random_param());

        // sender pauses until every result is back
        req_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);

        set_shape(4'd2, 7'd64);
        random_phase(60);
        calm = 1'b1;
        set_shape(4'd3, 7'd10);
        random_phase(80);
        calm = 1'b0;
        set_shape(4'd8, 7'd8);
        random_phase(40);

        for (int p = 0; p < 13; p++)
        begin
            order = $urandom_range(2, 8);
            count = $urandom_range(order, MAX_POINTS);
            if ($urandom_range(9) == 0) count = $urandom_range(2, 127);
            else if (order >= 6) count = $urandom_range(order, order + 6);
            set_shape(4'(order), 7'(count));
            random_phase(60);
        end

        req_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        repeat (700) @(posedge clk);

        $display("Sent %0d point writes and %0d evaluations over %0d order/count settings",
                 writes_sent, evals_sent, phases_run);
        $display("Checked %0d curve results, %0d of them error answers",
                 curves_checked, error_answers);
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
